[rtl/core/sha512_pkg.sv]
// Shared types, constants and round functions for the SHA-512 hasher.
package sha512_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_PREP,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_e;

  // Padding steps after the final request
  typedef enum logic [2:0] {
    PS_DATA,
    PS_MARK,
    PS_FILL,
    PS_LEN,
    PS_DONE
  } pad_e;

  localparam int unsigned WordW   = 64;
  localparam int unsigned Slots   = 16;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned Rounds  = 80;
  localparam int unsigned RoundW  = 7;
  localparam int unsigned HWords  = 8;
  localparam int unsigned HIdxW   = 3;
  localparam logic [3:0]  FullBytes = 4'd8;

  // Write request into the message word memory
  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] addr;
    logic [WordW-1:0] data;
  } wr_t;

  localparam logic [63:0] InitH [HWords] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [63:0] RoundK [Rounds] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] ror(input logic [63:0] v, input int unsigned n);
    ror = (v >> n) | (v << (64 - n));
  endfunction

  function automatic logic [63:0] bsig0(input logic [63:0] x);
    bsig0 = ror(x, 28) ^ ror(x, 34) ^ ror(x, 39);
  endfunction

  function automatic logic [63:0] bsig1(input logic [63:0] x);
    bsig1 = ror(x, 14) ^ ror(x, 18) ^ ror(x, 41);
  endfunction

  function automatic logic [63:0] ssig0(input logic [63:0] x);
    ssig0 = ror(x, 1) ^ ror(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [63:0] ssig1(input logic [63:0] x);
    ssig1 = ror(x, 19) ^ ror(x, 61) ^ (x >> 6);
  endfunction

endpackage

[rtl/core/sha512_wmem.sv]
// Sixteen-word message block memory, one write and one registered read.
module sha512_wmem (
  input  logic                                     clk_i,
  input  sha512_pkg::wr_t                          wr_i,
  input  logic [sha512_pkg::SlotW-1:0]             rd_addr_i,
  output logic [sha512_pkg::WordW-1:0]             rd_data_o
);

  logic [sha512_pkg::WordW-1:0] mem [sha512_pkg::Slots];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

[rtl/core/sha512_hash.sv]
// SHA-512 hasher top level: word buffering, padding, round sequencer and digest output.
//
//  channel | direction | fields                         | handshake
//  in      | sink      | data_i, valid_bytes_i, last_i  | in_valid_i / in_stall_o
//  out     | source    | digest_word_o, last_word_o     | out_valid_o / out_stall_i
//
// A non-final word is stored in the block memory; the word that fills a block is followed
// by one load, 80 rounds at one per cycle through the round logic, and one fold.
// A final word adds 3 to 18 padding writes and one or two block compressions,
// then eight digest words leave one per accepted cycle; input stalls meanwhile.
// Reset loads the initial hash values and clears length and slot counters.
// Output stalls hold the current digest word and the whole sequencer.
module sha512_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] data_i,
  input  logic [3:0]  valid_bytes_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] digest_word_o,
  output logic        last_word_o
);

  sha512_pkg::state_e state_q, state_d;
  sha512_pkg::pad_e   pad_q, pad_d;
  logic               pad_act_q, pad_act_d;
  logic [sha512_pkg::SlotW-1:0]  slot_q, slot_d;
  logic [sha512_pkg::RoundW-1:0] rnd_q, rnd_d;
  logic [sha512_pkg::HIdxW-1:0]  oidx_q, oidx_d;
  logic [63:0] bc_q, bc_d;
  logic [63:0] hold_q, hold_d;
  logic [63:0] mark_q, mark_d;

  logic [63:0] h_q  [sha512_pkg::HWords];
  logic [63:0] wk_q [sha512_pkg::HWords];
  logic [63:0] win_q [sha512_pkg::Slots];

  sha512_pkg::wr_t             wr;
  logic [sha512_pkg::SlotW-1:0] rd_addr;
  logic [63:0]                  rd_data;

  logic        in_acc, out_acc;
  logic [3:0]  nb;
  logic [5:0]  sh;
  logic        load_h, fold_h, reinit_h, do_round;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // saturated byte count of a final request
  assign nb = (valid_bytes_i > sha512_pkg::FullBytes) ? sha512_pkg::FullBytes : valid_bytes_i;
  assign sh = {nb[2:0], 3'b000};

  sha512_wmem u_wmem (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // sequencer: next state and control
  always_comb begin
    state_d   = state_q;
    pad_d     = pad_q;
    pad_act_d = pad_act_q;
    slot_d    = slot_q;
    rnd_d     = rnd_q;
    oidx_d    = oidx_q;
    bc_d      = bc_q;
    hold_d    = hold_q;
    mark_d    = mark_q;
    wr        = '0;
    rd_addr   = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    load_h    = 1'b0;
    fold_h    = 1'b0;
    reinit_h  = 1'b0;
    do_round  = 1'b0;
    case (state_q)
      sha512_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_acc) begin
          if (!last_i) begin
            wr.en   = 1'b1;
            wr.addr = slot_q;
            wr.data = data_i;
            slot_d  = slot_q + 1'b1;
            bc_d    = bc_q + 64'd64;
            if (slot_q == sha512_pkg::SlotW'(sha512_pkg::Slots - 1)) begin
              state_d = sha512_pkg::ST_PREP;
            end
          end else begin
            bc_d      = bc_q + {57'd0, nb, 3'b000};
            hold_d    = data_i;
            mark_d    = (data_i & ~(64'hffff_ffff_ffff_ffff >> sh)) |
                        (64'h8000_0000_0000_0000 >> sh);
            pad_d     = (nb == sha512_pkg::FullBytes) ? sha512_pkg::PS_DATA
                                                      : sha512_pkg::PS_MARK;
            pad_act_d = 1'b1;
            state_d   = sha512_pkg::ST_PAD;
          end
        end
      end
      sha512_pkg::ST_PAD: begin
        wr.en   = 1'b1;
        wr.addr = slot_q;
        slot_d  = slot_q + 1'b1;
        case (pad_q)
          sha512_pkg::PS_DATA: begin
            wr.data = hold_q;
            mark_d  = 64'h8000_0000_0000_0000;
            pad_d   = sha512_pkg::PS_MARK;
          end
          sha512_pkg::PS_MARK: begin
            wr.data = mark_q;
            pad_d   = sha512_pkg::PS_FILL;
          end
          sha512_pkg::PS_FILL: begin
            wr.data = '0;
            if (slot_q == sha512_pkg::SlotW'(sha512_pkg::Slots - 2)) begin
              pad_d = sha512_pkg::PS_LEN;
            end
          end
          default: begin
            wr.data = bc_q;
            pad_d   = sha512_pkg::PS_DONE;
          end
        endcase
        if (slot_q == sha512_pkg::SlotW'(sha512_pkg::Slots - 1)) begin
          state_d = sha512_pkg::ST_PREP;
        end
      end
      sha512_pkg::ST_PREP: begin
        load_h  = 1'b1;
        rd_addr = '0;
        rnd_d   = '0;
        state_d = sha512_pkg::ST_ROUND;
      end
      sha512_pkg::ST_ROUND: begin
        do_round = 1'b1;
        rd_addr  = rnd_q[sha512_pkg::SlotW-1:0] + 1'b1;
        rnd_d    = rnd_q + 1'b1;
        if (rnd_q == sha512_pkg::RoundW'(sha512_pkg::Rounds - 1)) begin
          state_d = sha512_pkg::ST_FOLD;
        end
      end
      sha512_pkg::ST_FOLD: begin
        fold_h = 1'b1;
        rnd_d  = '0;
        if (!pad_act_q) begin
          state_d = sha512_pkg::ST_IDLE;
        end else if (pad_q == sha512_pkg::PS_DONE) begin
          oidx_d  = '0;
          state_d = sha512_pkg::ST_OUT;
        end else begin
          state_d = sha512_pkg::ST_PAD;
        end
      end
      sha512_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_acc) begin
          oidx_d = oidx_q + 1'b1;
          if (oidx_q == sha512_pkg::HIdxW'(sha512_pkg::HWords - 1)) begin
            reinit_h  = 1'b1;
            bc_d      = '0;
            slot_d    = '0;
            pad_act_d = 1'b0;
            state_d   = sha512_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = sha512_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sha512_pkg::ST_IDLE;
      pad_q     <= sha512_pkg::PS_DONE;
      pad_act_q <= 1'b0;
      slot_q    <= '0;
      rnd_q     <= '0;
      oidx_q    <= '0;
      bc_q      <= '0;
    end else begin
      state_q   <= state_d;
      pad_q     <= pad_d;
      pad_act_q <= pad_act_d;
      slot_q    <= slot_d;
      rnd_q     <= rnd_d;
      oidx_q    <= oidx_d;
      bc_q      <= bc_d;
    end
  end

  // padding word holders
  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    mark_q <= mark_d;
  end

  // round datapath: schedule word, then the two temporaries
  logic [63:0] w, t1, t2, ch, maj;
  always_comb begin
    if (rnd_q < sha512_pkg::RoundW'(sha512_pkg::Slots)) begin
      w = rd_data;
    end else begin
      w = win_q[0] + sha512_pkg::ssig0(win_q[1]) + win_q[9] + sha512_pkg::ssig1(win_q[14]);
    end
    ch  = (wk_q[4] & wk_q[5]) ^ (~wk_q[4] & wk_q[6]);
    maj = (wk_q[0] & wk_q[1]) ^ (wk_q[0] & wk_q[2]) ^ (wk_q[1] & wk_q[2]);
    t1  = wk_q[7] + sha512_pkg::bsig1(wk_q[4]) + ch + sha512_pkg::RoundK[rnd_q] + w;
    t2  = sha512_pkg::bsig0(wk_q[0]) + maj;
  end

  // working variables and schedule window
  always_ff @(posedge clk_i) begin
    if (load_h) begin
      for (int i = 0; i < sha512_pkg::HWords; i++) begin
        wk_q[i] <= h_q[i];
      end
    end else if (do_round) begin
      wk_q[7] <= wk_q[6];
      wk_q[6] <= wk_q[5];
      wk_q[5] <= wk_q[4];
      wk_q[4] <= wk_q[3] + t1;
      wk_q[3] <= wk_q[2];
      wk_q[2] <= wk_q[1];
      wk_q[1] <= wk_q[0];
      wk_q[0] <= t1 + t2;
      for (int i = 0; i < sha512_pkg::Slots - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[sha512_pkg::Slots-1] <= w;
    end
  end

  // hash state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sha512_pkg::HWords; i++) begin
        h_q[i] <= sha512_pkg::InitH[i];
      end
    end else if (fold_h) begin
      for (int i = 0; i < sha512_pkg::HWords; i++) begin
        h_q[i] <= h_q[i] + wk_q[i];
      end
    end else if (reinit_h) begin
      for (int i = 0; i < sha512_pkg::HWords; i++) begin
        h_q[i] <= sha512_pkg::InitH[i];
      end
    end
  end

  assign digest_word_o = h_q[oidx_q];
  assign last_word_o   = (oidx_q == sha512_pkg::HIdxW'(sha512_pkg::HWords - 1));

endmodule

[rtl/core/sha512_chk.sv]
// Port-level checks for the SHA-512 hasher and their binding.
module sha512_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        last_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] digest_word_o,
  input logic        last_word_o
);

  // a stalled digest word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(digest_word_o)
                                   && $stable(last_word_o))
    else $error("stalled digest word changed");

  // no input request taken while the digest drains
  a_in_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open during digest output");

  // the final digest word ends the output burst
  a_burst_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_word_o |=> !out_valid_o)
    else $error("output continued after final word");

  // padding and compression follow a final request before any digest
  a_pad_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_i |=> !out_valid_o ##1 !out_valid_o)
    else $error("digest appeared too early");

endmodule

bind sha512_hash sha512_chk u_sha512_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .last_i        (last_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .digest_word_o (digest_word_o),
  .last_word_o   (last_word_o)
);

[tb/sha512_checker.sv]
// Checker for the SHA-512 hasher: watches both channels, predicts digests, compares.
module sha512_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [63:0] data_i,
  input  logic [3:0]  valid_bytes_i,
  input  logic        last_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [63:0] digest_word_i,
  input  logic        last_word_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          digests_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] word;
    logic        fin;
  } digest_t;

  logic [63:0] hash_q [sha512_pkg::HWords];
  logic [63:0] block_q [sha512_pkg::Slots];
  logic [63:0] msg_bits;
  logic [3:0]  fill_slot;
  digest_t     digest_fifo [$];

  function automatic logic [63:0] rotr(input logic [63:0] v, input int n);
    return (v >> n) | (v << (64 - n));
  endfunction

  // Compress the buffered block into the running hash
  task automatic run_block();
    logic [63:0] v [8];
    logic [63:0] sched [16];
    logic [63:0] w, s0, s1, t1, t2, ch, mj;
    for (int i = 0; i < 8; i++) v[i] = hash_q[i];
    for (int i = 0; i < 16; i++) sched[i] = block_q[i];
    for (int r = 0; r < sha512_pkg::Rounds; r++) begin
      if (r >= 16) begin
        w = sched[(r - 15) & 15];
        s0 = rotr(w, 1) ^ rotr(w, 8) ^ (w >> 7);
        w = sched[(r - 2) & 15];
        s1 = rotr(w, 19) ^ rotr(w, 61) ^ (w >> 6);
        sched[r & 15] = sched[r & 15] + s0 + sched[(r - 7) & 15] + s1;
      end
      w = sched[r & 15];
      s1 = rotr(v[4], 14) ^ rotr(v[4], 18) ^ rotr(v[4], 41);
      ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1 = v[7] + s1 + ch + sha512_pkg::RoundK[r] + w;
      s0 = rotr(v[0], 28) ^ rotr(v[0], 34) ^ rotr(v[0], 39);
      mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t2 = s0 + mj;
      for (int k = 7; k > 0; k--) v[k] = v[k-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_q[i] += v[i];
  endtask

  task automatic put_word(input logic [63:0] w);
    block_q[fill_slot] = w;
    fill_slot++;
    if (fill_slot == 0) run_block();
  endtask

  // Absorb one request; on the final one pad and queue the digest
  task automatic absorb(input logic [63:0] d, input logic [3:0] nb, input logic fin);
    logic [63:0] keep;
    int n;
    if (!fin) begin
      put_word(d);
      msg_bits += 64;
      return;
    end
    n = (nb > sha512_pkg::FullBytes) ? 8 : int'(nb);
    msg_bits += 64'(n * 8);
    if (n == 8) begin
      put_word(d);
      put_word(64'h80 << 56);
    end else begin
      keep = (n == 0) ? '0 : ('1 << (64 - 8 * n));
      put_word((d & keep) | (64'h80 << (56 - 8 * n)));
    end
    while (fill_slot != 14) put_word('0);
    put_word('0);
    put_word(msg_bits);
    for (int i = 0; i < 8; i++) begin
      digest_fifo.insert(digest_fifo.size(), digest_t'{hash_q[i], (i == 7)});
    end
    for (int i = 0; i < 8; i++) hash_q[i] = sha512_pkg::InitH[i];
    msg_bits = '0;
    fill_slot = '0;
  endtask

  digest_t exp_d;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) hash_q[i] = sha512_pkg::InitH[i];
      msg_bits = '0;
      fill_slot = '0;
      digest_fifo.delete();
      fail_count_o = 0;
      digests_o = 0;
    end else begin
      // Output side
      if (out_valid_i && !out_stall_i) begin
        if (digest_fifo.size() == 0) begin
          $error("digest word %h with nothing expected", digest_word_i);
          fail_count_o++;
        end else begin
          exp_d = digest_fifo.pop_front();
          if (digest_word_i !== exp_d.word) begin
            $error("digest_word: expected %h actual %h", exp_d.word, digest_word_i);
            fail_count_o++;
          end
          if (last_word_i !== exp_d.fin) begin
            $error("last_word: expected %0d actual %0d", exp_d.fin, last_word_i);
            fail_count_o++;
          end
          if (exp_d.fin) digests_o++;
        end
      end
      // Input side
      if (in_valid_i && !in_stall_i) absorb(data_i, valid_bytes_i, last_i);
    end
    pending_o = digest_fifo.size();
  end
endmodule

[tb/testbench.sv]
// Top of the SHA-512 hasher testbench: clock, reset, requests, idling and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] data_i = '0;
  logic [3:0]  valid_bytes_i = '0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] digest_word_o;
  logic        last_word_o;
  int          fail_count, pending, digests;
  int          quiet_cycles = 0;
  int          sent;
  bit          calm;

  localparam int StallLimit = 20000;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  sha512_hash u_top (.*);

  sha512_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .data_i, .valid_bytes_i,
    .last_i, .out_valid_i(out_valid_o), .out_stall_i, .digest_word_i(digest_word_o),
    .last_word_i(last_word_o), .fail_count_o(fail_count), .pending_o(pending),
    .digests_o(digests)
  );

  // Receiver stalls at random except during the calm stretch
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 7);
  end

  // Watchdog on cycles with no accepted request or digest word
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Present one request and hold it until accepted; valid drops only while idling
  task automatic send(input logic [63:0] d, input logic [3:0] nb, input logic fin);
    while (!calm && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_i        <= d;
    valid_bytes_i <= nb;
    last_i        <= fin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Message of the given word count followed by a tail word
  task automatic send_msg(input int words, input logic [63:0] tail, input logic [3:0] nb);
    for (int i = 0; i < words; i++) send(rand64(), 4'($urandom_range(15)), 1'b0);
    send(tail, nb, 1'b1);
  endtask

  int nw;

  initial begin
    sent = 0;
    calm = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: empty message, three-byte, full tail, tails at padding boundaries
    send_msg(0, '0, 4'd0);
    send_msg(0, 64'h6162630000000000, 4'd3);
    send_msg(0, '1, 4'd8);
    send_msg(0, '1, 4'd15);
    send_msg(13, '1, 4'd7);
    send_msg(14, '0, 4'd8);
    send_msg(15, '1, 4'd1);
    // Random: mostly short messages, a few spanning several blocks
    while (sent < 370) begin
      calm = (sent > 150 && sent < 230);
      nw = ($urandom_range(9) == 0) ? int'($urandom_range(40)) : int'($urandom_range(6));
      send_msg(nw, rand64(), 4'($urandom_range(15)));
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Covered %0d requests and %0d digests, tails of every byte count.",
             sent, digests);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/core/sha512_pkg.sv
rtl/core/sha512_wmem.sv
rtl/core/sha512_hash.sv
rtl/core/sha512_chk.sv
tb/sha512_checker.sv
tb/testbench.sv
